/* rtl/core/bcd_pkg.sv */
// bcd_pkg: shared types and constants for the button click event detector.
// Used by bcd_debounce and button_click_event_detector_unit; no dependencies.
`timescale 1ns / 1ps

package bcd_pkg;

    // Field and register widths
    localparam int TICK_WIDTH     = 16;
    localparam int DEB_WIDTH      = 3;
    localparam int THRESH_WIDTH   = 16;
    localparam int EVENT_WIDTH    = 3;
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = 16;
    localparam int TDATA_WIDTH    = 8;

    // Reset values of the configuration registers
    localparam logic                    RST_PRESS_LEVEL  = 1'b0;
    localparam logic [DEB_WIDTH-1:0]    RST_DEB_TICKS    = 3'd3;
    localparam logic [THRESH_WIDTH-1:0] RST_CLICK_TICKS  = 16'd80;
    localparam logic [THRESH_WIDTH-1:0] RST_LONG_TICKS   = 16'd200;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_PRESS_LEVEL  = 2'd0,
        CFG_DEB_TICKS    = 2'd1,
        CFG_CLICK_TICKS  = 2'd2,
        CFG_LONG_TICKS   = 2'd3
    } t_cfg_idx;

    // Event codes on the result channel
    typedef enum logic [EVENT_WIDTH-1:0] {
        EV_NONE       = 3'd0,
        EV_SINGLE     = 3'd1,
        EV_DOUBLE     = 3'd2,
        EV_LONG_START = 3'd3,
        EV_LONG_HOLD  = 3'd4,
        EV_LONG_STOP  = 3'd5
    } t_event;

    // Press recognizer modes, one-hot
    typedef enum logic [4:0] {
        MODE_IDLE     = 5'b00001,
        MODE_PRESSED  = 5'b00010,
        MODE_RELEASED = 5'b00100,
        MODE_SECOND   = 5'b01000,
        MODE_LONG     = 5'b10000
    } t_mode;

    // Settings that the debouncer needs
    typedef struct packed {
        logic                 press_level;
        logic [DEB_WIDTH-1:0] deb_ticks;
    } t_deb_cfg;

endpackage

/* rtl/core/button_click_event_detector_unit.sv */
// button_click_event_detector_unit: top level; debounced press recognizer with a
// registered result stage. Depends on bcd_pkg and bcd_debounce.
`timescale 1ns / 1ps

// Channel  | Dir | tdata bits (low first)             | Handshake
// ---------+-----+------------------------------------+-------------------------------
// s_axis   | in  | [0] pin_sample, [7:1] zero         | tvalid & tready
// m_axis   | out | [2:0] event_code, [3] pressed_now  | tvalid & tready
// cfg      | in  | wdata[15:0], index[1:0]            | write when i_cfg_we is high
//
// Each accepted item updates the debounce and recognizer in one pass, and the
// result sits in the output register on the next cycle.
// One item per cycle is sustained; tready drops only while a result waits and
// m_axis_tready is low. Synchronous active-low reset returns the state to not
// pressed / idle, loads the register defaults and empties the output register.

module button_click_event_detector_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Sample channel
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [bcd_pkg::TDATA_WIDTH-1:0]     i_s_axis_tdata,  // [0] pin_sample
    // Result channel
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [bcd_pkg::TDATA_WIDTH-1:0]     o_m_axis_tdata,  // [2:0] event_code, [3] pressed_now
    // Configuration writes
    input  logic                                i_cfg_we,
    input  logic [bcd_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_index,
    input  logic [bcd_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_wdata
);

    // Configuration registers
    logic                             r_press_level;
    logic [bcd_pkg::DEB_WIDTH-1:0]    r_deb_ticks;
    logic [bcd_pkg::THRESH_WIDTH-1:0] r_click_ticks;
    logic [bcd_pkg::THRESH_WIDTH-1:0] r_long_ticks;

    // Recognizer state
    bcd_pkg::t_mode                   r_mode;
    bcd_pkg::t_mode                   n_mode;
    logic [bcd_pkg::TICK_WIDTH-1:0]   r_tick;
    logic [bcd_pkg::TICK_WIDTH-1:0]   n_tick;
    logic [bcd_pkg::TICK_WIDTH-1:0]   tick_inc;

    // Output register
    logic                             r_out_valid;
    bcd_pkg::t_event                  r_out_event;
    logic                             r_out_pressed;
    bcd_pkg::t_event                  n_event;

    logic                             in_accept;
    logic                             pressed;
    bcd_pkg::t_deb_cfg                deb_cfg;

    // Accept while the output register is free or being drained
    assign o_s_axis_tready = ~r_out_valid | i_m_axis_tready;
    assign in_accept       = i_s_axis_tvalid & o_s_axis_tready;

    // Configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_level  <= bcd_pkg::RST_PRESS_LEVEL;
            r_deb_ticks    <= bcd_pkg::RST_DEB_TICKS;
            r_click_ticks  <= bcd_pkg::RST_CLICK_TICKS;
            r_long_ticks   <= bcd_pkg::RST_LONG_TICKS;
        end else if (i_cfg_we) begin
            case (bcd_pkg::t_cfg_idx'(i_cfg_index))
                bcd_pkg::CFG_PRESS_LEVEL:  r_press_level  <= i_cfg_wdata[0];
                bcd_pkg::CFG_DEB_TICKS:    r_deb_ticks    <= i_cfg_wdata[bcd_pkg::DEB_WIDTH-1:0];
                bcd_pkg::CFG_CLICK_TICKS:  r_click_ticks  <= i_cfg_wdata[bcd_pkg::THRESH_WIDTH-1:0];
                bcd_pkg::CFG_LONG_TICKS:   r_long_ticks   <= i_cfg_wdata[bcd_pkg::THRESH_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Debouncer
    assign deb_cfg.press_level = r_press_level;
    assign deb_cfg.deb_ticks   = r_deb_ticks;

    bcd_debounce u_debounce (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (in_accept),
        .i_pin          (i_s_axis_tdata[0]),
        .i_cfg          (deb_cfg),
        .o_pressed_next (pressed)
    );

    // Tick counter runs whenever the recognizer is busy
    assign tick_inc = (r_mode != bcd_pkg::MODE_IDLE) ? r_tick + 1'b1 : r_tick;

    // Press recognizer
    always_comb begin
        n_mode  = r_mode;
        n_tick  = tick_inc;
        n_event = bcd_pkg::EV_NONE;
        case (r_mode)
            bcd_pkg::MODE_IDLE: begin
                if (pressed) begin
                    n_tick = '0;
                    n_mode = bcd_pkg::MODE_PRESSED;
                end
            end
            bcd_pkg::MODE_PRESSED: begin
                if (!pressed) begin
                    n_mode = bcd_pkg::MODE_RELEASED;
                end else if (tick_inc > r_long_ticks) begin
                    n_event = bcd_pkg::EV_LONG_START;
                    n_mode  = bcd_pkg::MODE_LONG;
                end
            end
            bcd_pkg::MODE_RELEASED: begin
                if (tick_inc > r_click_ticks) begin
                    n_event = bcd_pkg::EV_SINGLE;
                    n_mode  = bcd_pkg::MODE_IDLE;
                end else if (pressed) begin
                    n_mode = bcd_pkg::MODE_SECOND;
                end
            end
            bcd_pkg::MODE_SECOND: begin
                if (!pressed) begin
                    n_event = bcd_pkg::EV_DOUBLE;
                    n_mode  = bcd_pkg::MODE_IDLE;
                end
            end
            bcd_pkg::MODE_LONG: begin
                if (pressed) begin
                    n_event = bcd_pkg::EV_LONG_HOLD;
                end else begin
                    n_event = bcd_pkg::EV_LONG_STOP;
                    n_mode  = bcd_pkg::MODE_IDLE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= bcd_pkg::MODE_IDLE;
            r_tick <= '0;
        end else if (in_accept) begin
            r_mode <= n_mode;
            r_tick <= n_tick;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_event   <= n_event;
            r_out_pressed <= pressed;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(bcd_pkg::TDATA_WIDTH - bcd_pkg::EVENT_WIDTH - 1){1'b0}},
                              r_out_pressed, r_out_event};

    // Assertions
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_idle_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_mode == bcd_pkg::MODE_IDLE) |=> (r_out_event == bcd_pkg::EV_NONE))
        else $error("event reported from idle");

    a_long_hold_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_mode == bcd_pkg::MODE_LONG)
            |=> (r_out_event == bcd_pkg::EV_LONG_HOLD || r_out_event == bcd_pkg::EV_LONG_STOP))
        else $error("long press gave an event other than hold or stop");

    a_stop_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (n_event == bcd_pkg::EV_LONG_STOP || n_event == bcd_pkg::EV_DOUBLE
            || n_event == bcd_pkg::EV_SINGLE)) |=> (r_mode == bcd_pkg::MODE_IDLE))
        else $error("recognizer not idle after a closing event");

endmodule

/* rtl/core/bcd_debounce.sv */
// bcd_debounce: pin debouncer holding the accepted pressed state and run count.
// Depends on bcd_pkg.
`timescale 1ns / 1ps

module bcd_debounce (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,          // an item is taken this cycle
    input  logic              i_pin,
    input  bcd_pkg::t_deb_cfg i_cfg,
    output logic              o_pressed_next   // debounced state after this item
);

    logic                          r_pressed;
    logic [bcd_pkg::DEB_WIDTH-1:0] r_count;
    logic                          n_pressed;
    logic [bcd_pkg::DEB_WIDTH-1:0] n_count;
    logic                          level;
    logic [bcd_pkg::DEB_WIDTH-1:0] count_inc;

    // Pin level that the current state stands for
    assign level     = r_pressed ? i_cfg.press_level : ~i_cfg.press_level;
    assign count_inc = r_count + 1'b1;

    // Count differing samples; flip once the run is long enough
    always_comb begin
        n_pressed = r_pressed;
        n_count   = '0;
        if (i_pin != level) begin
            if (count_inc >= i_cfg.deb_ticks) begin
                n_pressed = ~r_pressed;
            end else begin
                n_count = count_inc;
            end
        end
    end

    assign o_pressed_next = n_pressed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed <= 1'b0;
            r_count   <= '0;
        end else if (i_step) begin
            r_pressed <= n_pressed;
            r_count   <= n_count;
        end
    end

endmodule
